[src/mlfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfc_pkg: shared types and constants of the multichannel FIR convolver
// Sizes, item structs and arithmetic widths used by every module but the generic RAM.
// ----------------------------------------------------------------------------
package mlfc_pkg;

   localparam int CHANNELS    = 4;
   localparam int MAX_TAPS    = 4096;
   localparam int SAMPLE_BITS = 24;

   localparam int RESULT_LIMIT  = 4;
   localparam int CHAN_LIM      = (CHANNELS < RESULT_LIMIT) ? CHANNELS : RESULT_LIMIT;
   localparam int RESET_TAPS    = 256;
   localparam int RESET_CHANS   = 1;

   localparam int TC_W       = 13;
   localparam int CC_W       = 3;
   localparam int TCHAN_W    = 2;
   localparam int TIDX_W     = 12;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int TAP_IDX_W = $clog2(MAX_TAPS);
   localparam int TAP_CNT_W = $clog2(MAX_TAPS + 1);
   localparam int CHAN_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int FRAC_W = SAMPLE_BITS - 1;
   localparam int ACC_W  = 2 * SAMPLE_BITS + TAP_IDX_W;
   localparam int RND_W  = ACC_W + 1 - FRAC_W;

   localparam logic signed [ACC_W:0]   RND_BIAS = (ACC_W + 1)'(64'sd1 <<< (FRAC_W - 1));
   localparam logic signed [RND_W-1:0] SAT_MAX  =
      RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [RND_W-1:0] SAT_MIN  = RND_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

   localparam int CMD_DEPTH = 4;
   localparam int CQ_PTR_W  = $clog2(CMD_DEPTH);
   localparam int CQ_CNT_W  = $clog2(CMD_DEPTH + 1);
   localparam int RES_DEPTH = 4;
   localparam int RQ_PTR_W  = $clog2(RES_DEPTH);
   localparam int RQ_CNT_W  = $clog2(RES_DEPTH + 1);

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   localparam logic REG_TAP_COUNT     = 1'b0;
   localparam logic REG_CHANNEL_COUNT = 1'b1;

   typedef struct packed {
      logic                          op;
      logic signed [SAMPLE_BITS-1:0] sample_value;
      logic [TCHAN_W-1:0]            tap_channel;
      logic [TIDX_W-1:0]             tap_index;
      logic signed [SAMPLE_BITS-1:0] tap_value;
   } req_type;

   typedef struct packed {
      logic [TCHAN_W-1:0]            out_channel;
      logic signed [SAMPLE_BITS-1:0] out_value;
      logic                          clipped;
      logic                          last;
   } rsp_type;

   typedef struct packed {
      logic                          load;
      logic [TCHAN_W-1:0]            tap_channel;
      logic [TIDX_W-1:0]             tap_index;
      logic signed [SAMPLE_BITS-1:0] value;
   } cmd_type;

endpackage

[src/mlfc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mlfc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[src/mlfc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfc_front: input side of the convolver
// Accepts items, drops out-of-range tap loads and queues commands.
// ----------------------------------------------------------------------------
module mlfc_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  mlfc_pkg::req_type  req_item,
   output logic               cmd_valid,
   input  logic               cmd_pop,
   output mlfc_pkg::cmd_type  cmd
);

   mlfc_pkg::cmd_type               queue_ff [mlfc_pkg::CMD_DEPTH];
   logic [mlfc_pkg::CQ_PTR_W-1:0]   wr_ff, wr_in;
   logic [mlfc_pkg::CQ_PTR_W-1:0]   rd_ff, rd_in;
   logic [mlfc_pkg::CQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            accept;
   logic                            keep;
   logic                            wr_en;
   logic                            rd_en;
   mlfc_pkg::cmd_type               new_cmd;

   assign full   = (cnt_ff == mlfc_pkg::CQ_CNT_W'(mlfc_pkg::CMD_DEPTH));
   assign accept = push && !full;

   always_comb begin
      keep = (req_item.op == mlfc_pkg::OP_SAMPLE) ||
             ((32'(req_item.tap_channel) < mlfc_pkg::CHANNELS) &&
              (32'(req_item.tap_index) < mlfc_pkg::MAX_TAPS));
      new_cmd.load        = (req_item.op == mlfc_pkg::OP_LOAD);
      new_cmd.tap_channel = req_item.tap_channel;
      new_cmd.tap_index   = req_item.tap_index;
      new_cmd.value       = (req_item.op == mlfc_pkg::OP_LOAD) ? req_item.tap_value
                                                               : req_item.sample_value;
   end

   assign wr_en     = accept && keep;
   assign cmd_valid = (cnt_ff != '0);
   assign rd_en     = cmd_pop && cmd_valid;
   assign cmd       = queue_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (wr_en) begin
         wr_in = (wr_ff == mlfc_pkg::CQ_PTR_W'(mlfc_pkg::CMD_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_in = (rd_ff == mlfc_pkg::CQ_PTR_W'(mlfc_pkg::CMD_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_ff] <= new_cmd;
      end
   end

endmodule

[src/mlfc_resq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfc_resq: result queue
// Holds finished results until the consumer pops them.
// ----------------------------------------------------------------------------
module mlfc_resq (
   input  logic               clock,
   input  logic               reset,
   input  logic               res_push,
   input  mlfc_pkg::rsp_type  res_item,
   output logic               res_full,
   output logic               empty,
   input  logic               pop,
   output mlfc_pkg::rsp_type  rsp_item
);

   mlfc_pkg::rsp_type               queue_ff [mlfc_pkg::RES_DEPTH];
   logic [mlfc_pkg::RQ_PTR_W-1:0]   wr_ff, wr_in;
   logic [mlfc_pkg::RQ_PTR_W-1:0]   rd_ff, rd_in;
   logic [mlfc_pkg::RQ_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                            wr_en;
   logic                            rd_en;

   assign res_full = (cnt_ff == mlfc_pkg::RQ_CNT_W'(mlfc_pkg::RES_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign wr_en    = res_push && !res_full;
   assign rd_en    = pop && !empty;
   assign rsp_item = queue_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (wr_en) begin
         wr_in = (wr_ff == mlfc_pkg::RQ_PTR_W'(mlfc_pkg::RES_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_in = (rd_ff == mlfc_pkg::RQ_PTR_W'(mlfc_pkg::RES_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_ff] <= res_item;
      end
   end

endmodule

[src/mlfc_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlfc_back: convolution engine
// Executes tap loads and samples: one history read per cycle feeds one
// multiply-accumulate lane per channel, then rounds, saturates and emits.
// ----------------------------------------------------------------------------
module mlfc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cmd_valid,
   output logic                       cmd_pop,
   input  mlfc_pkg::cmd_type          cmd,
   input  logic [mlfc_pkg::TC_W-1:0]  tap_count,
   input  logic [mlfc_pkg::CC_W-1:0]  channel_count,
   input  logic                       res_full,
   output logic                       res_push,
   output mlfc_pkg::rsp_type          res_item
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_TAIL  = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   localparam int SB = mlfc_pkg::SAMPLE_BITS;
   localparam int IW = mlfc_pkg::TAP_IDX_W;
   localparam int CW = mlfc_pkg::TAP_CNT_W;
   localparam int NC = mlfc_pkg::CHANNELS;

   logic [2:0]                    state_ff, state_in;
   logic [IW-1:0]                 k_ff, k_in;
   logic [IW-1:0]                 hrd_ff, hrd_in;
   logic [IW-1:0]                 ptr_ff, ptr_in;
   logic [CW-1:0]                 fill_ff, fill_in;
   logic                          va_ff, va_in;
   logic                          live_ff, live_in;
   logic                          vb_ff, vb_in;
   logic [mlfc_pkg::CHAN_W-1:0]   c_ff, c_in;

   logic signed [2*SB-1:0]               prod_ff [NC];
   logic signed [2*SB-1:0]               prod_in [NC];
   logic signed [mlfc_pkg::ACC_W-1:0]    acc_ff  [NC];
   logic signed [mlfc_pkg::ACC_W-1:0]    acc_in  [NC];
   logic signed [mlfc_pkg::RND_W-1:0]    rnd_ff  [NC];
   logic signed [mlfc_pkg::RND_W-1:0]    rnd_in  [NC];
   logic signed [mlfc_pkg::ACC_W:0]      biased  [NC];

   logic [SB-1:0]                 tap_q [NC];
   logic [SB-1:0]                 hist_q;
   logic                          take;
   logic                          start;
   logic                          hist_we;
   logic [CW-1:0]                 taps_eff;
   logic [mlfc_pkg::CC_W-1:0]     chans_eff;
   logic                          run_end;
   logic                          last_ch;
   logic signed [mlfc_pkg::RND_W-1:0] sel;

   always_comb begin
      if (tap_count == '0) begin
         taps_eff = CW'(1);
      end else if (32'(tap_count) > mlfc_pkg::MAX_TAPS) begin
         taps_eff = CW'(mlfc_pkg::MAX_TAPS);
      end else begin
         taps_eff = CW'(tap_count);
      end
      if (channel_count == '0) begin
         chans_eff = mlfc_pkg::CC_W'(1);
      end else if (32'(channel_count) > mlfc_pkg::CHAN_LIM) begin
         chans_eff = mlfc_pkg::CC_W'(mlfc_pkg::CHAN_LIM);
      end else begin
         chans_eff = channel_count;
      end
   end

   assign take    = (state_ff == ST_IDLE) && cmd_valid;
   assign cmd_pop = take;
   assign start   = take && !cmd.load;
   assign hist_we = start;
   assign run_end = (CW'(k_ff) == taps_eff - CW'(1));
   assign last_ch = (mlfc_pkg::CC_W'(c_ff) + mlfc_pkg::CC_W'(1) == chans_eff);

   mlfc_ram #(
      .WIDTH (SB),
      .DEPTH (mlfc_pkg::MAX_TAPS)
   ) u_hist_ram (
      .clock (clock),
      .we    (hist_we),
      .waddr (ptr_ff),
      .wdata (cmd.value),
      .raddr (hrd_ff),
      .rdata (hist_q)
   );

   for (genvar c = 0; c < NC; c++) begin : g_lane
      mlfc_ram #(
         .WIDTH (SB),
         .DEPTH (mlfc_pkg::MAX_TAPS)
      ) u_tap_ram (
         .clock (clock),
         .we    (take && cmd.load && (32'(cmd.tap_channel) == c)),
         .waddr (IW'(cmd.tap_index)),
         .wdata (cmd.value),
         .raddr (k_ff),
         .rdata (tap_q[c])
      );
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      hrd_in   = hrd_ff;
      ptr_in   = ptr_ff;
      fill_in  = fill_ff;
      va_in    = 1'b0;
      live_in  = 1'b0;
      vb_in    = va_ff;
      c_in     = c_ff;
      res_push = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               k_in     = '0;
               hrd_in   = ptr_ff;
               ptr_in   = (ptr_ff == IW'(mlfc_pkg::MAX_TAPS - 1)) ? '0 : ptr_ff + 1'b1;
               fill_in  = (fill_ff == CW'(mlfc_pkg::MAX_TAPS)) ? fill_ff : fill_ff + 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            va_in   = 1'b1;
            live_in = (CW'(k_ff) < fill_ff);
            k_in    = k_ff + 1'b1;
            hrd_in  = (hrd_ff == '0) ? IW'(mlfc_pkg::MAX_TAPS - 1) : hrd_ff - 1'b1;
            if (run_end) begin
               state_in = ST_TAIL;
            end
         end
         ST_TAIL: begin
            if (!va_ff && !vb_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            c_in     = '0;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!res_full) begin
               res_push = 1'b1;
               c_in     = c_ff + 1'b1;
               if (last_ch) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         if (live_ff) begin
            prod_in[c] = $signed(tap_q[c]) * $signed(hist_q);
         end else begin
            prod_in[c] = '0;
         end
         if (start) begin
            acc_in[c] = '0;
         end else if (vb_ff) begin
            acc_in[c] = acc_ff[c] + mlfc_pkg::ACC_W'(prod_ff[c]);
         end else begin
            acc_in[c] = acc_ff[c];
         end
         biased[c] = (mlfc_pkg::ACC_W + 1)'(acc_ff[c]) + mlfc_pkg::RND_BIAS;
         rnd_in[c] = (state_ff == ST_ROUND) ?
                     mlfc_pkg::RND_W'(biased[c] >>> mlfc_pkg::FRAC_W) : rnd_ff[c];
      end
   end

   always_comb begin
      sel                  = rnd_ff[c_ff];
      res_item.out_channel = mlfc_pkg::TCHAN_W'(c_ff);
      res_item.last        = last_ch;
      if (sel > mlfc_pkg::SAT_MAX) begin
         res_item.out_value = SB'(mlfc_pkg::SAT_MAX);
         res_item.clipped   = 1'b1;
      end else if (sel < mlfc_pkg::SAT_MIN) begin
         res_item.out_value = SB'(mlfc_pkg::SAT_MIN);
         res_item.clipped   = 1'b1;
      end else begin
         res_item.out_value = sel[SB-1:0];
         res_item.clipped   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         hrd_ff   <= '0;
         ptr_ff   <= '0;
         fill_ff  <= '0;
         va_ff    <= 1'b0;
         live_ff  <= 1'b0;
         vb_ff    <= 1'b0;
         c_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         hrd_ff   <= hrd_in;
         ptr_ff   <= ptr_in;
         fill_ff  <= fill_in;
         va_ff    <= va_in;
         live_ff  <= live_in;
         vb_ff    <= vb_in;
         c_ff     <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NC; c++) begin
         prod_ff[c] <= prod_in[c];
         acc_ff[c]  <= acc_in[c];
         rnd_ff[c]  <= rnd_in[c];
      end
   end

endmodule

[src/multichannel_long_fir_convolver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_long_fir_convolver_top: multichannel direct-form FIR convolver
// Convolves each audio sample with one stored impulse response per channel.
//
//   channel   ports                                   item
//   --------  --------------------------------------  -------------------------
//   request   push, full, req_item                    sample or tap load
//   response  empty, pop, rsp_item                    one result per active channel
//   csr       psel, penable, pwrite, paddr, pwdata,   tap_count @0,
//             prdata, pready                          channel_count @4
//
// A sample occupies the engine until all its results are pushed: the
// history RAM gives one read per cycle, with one MAC lane per channel.
// A tap load writes one lane's tap RAM from the idle state. A 4-entry command
// queue and a 4-entry result queue let input and output stall independently.
// Reset is synchronous; history is tracked by a fill count, so no clear pass.
// ----------------------------------------------------------------------------
module multichannel_long_fir_convolver_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  mlfc_pkg::req_type                 req_item,
   output logic                              empty,
   input  logic                              pop,
   output mlfc_pkg::rsp_type                 rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [mlfc_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [mlfc_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [mlfc_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);

   logic [mlfc_pkg::TC_W-1:0]  tap_count_ff, tap_count_in;
   logic [mlfc_pkg::CC_W-1:0]  channel_count_ff, channel_count_in;
   logic                       csr_wr;
   logic                       csr_idx;
   logic                       cmd_valid;
   logic                       cmd_pop;
   mlfc_pkg::cmd_type          cmd;
   logic                       res_full;
   logic                       res_push;
   mlfc_pkg::rsp_type          res_item;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = paddr[2];

   always_comb begin
      tap_count_in     = tap_count_ff;
      channel_count_in = channel_count_ff;
      if (csr_wr) begin
         case (csr_idx)
            mlfc_pkg::REG_TAP_COUNT:     tap_count_in     = pwdata[mlfc_pkg::TC_W-1:0];
            mlfc_pkg::REG_CHANNEL_COUNT: channel_count_in = pwdata[mlfc_pkg::CC_W-1:0];
            default: begin
            end
         endcase
      end
      case (csr_idx)
         mlfc_pkg::REG_TAP_COUNT: prdata = mlfc_pkg::CSR_DATA_W'(tap_count_ff);
         mlfc_pkg::REG_CHANNEL_COUNT: prdata = mlfc_pkg::CSR_DATA_W'(channel_count_ff);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= mlfc_pkg::TC_W'(mlfc_pkg::RESET_TAPS);
         channel_count_ff <= mlfc_pkg::CC_W'(mlfc_pkg::RESET_CHANS);
      end else begin
         tap_count_ff     <= tap_count_in;
         channel_count_ff <= channel_count_in;
      end
   end

   mlfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   mlfc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop),
      .cmd           (cmd),
      .tap_count     (tap_count_ff),
      .channel_count (channel_count_ff),
      .res_full      (res_full),
      .res_push      (res_push),
      .res_item      (res_item)
   );

   mlfc_resq u_resq (
      .clock    (clock),
      .reset    (reset),
      .res_push (res_push),
      .res_item (res_item),
      .res_full (res_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule
